/* hdl/sbad_pkg.sv */
// ----------------------------------------------------------------------------
// sbad_pkg
// Shared types and constants for the stereo box-average downsampler.
// ----------------------------------------------------------------------------
package sbad_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned MixW     = SampleW + 1;
  localparam int unsigned RateW    = 18;
  localparam int unsigned SumW     = 36;
  localparam int unsigned DivRemW  = RateW + 2;
  localparam int unsigned DivSteps = SampleW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [RateW-1:0]   InRateRst  = 18'd44100;
  localparam logic [RateW-1:0]   OutRateRst = 18'd16000;
  localparam logic [SampleW-1:0] MonoMax    = 16'h7fff;
  localparam logic [SampleW-1:0] MonoMin    = 16'h8000;

  typedef enum logic [0:0] {
    CFG_IN_RATE  = 1'b0,
    CFG_DST_RATE = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

endpackage

/* hdl/stereo_box_average_downsampler.sv */
// ----------------------------------------------------------------------------
// stereo_box_average_downsampler
// Stereo to mono downmix with exact area-average rate reduction.
// ----------------------------------------------------------------------------
// Each accepted stereo frame is summed to mono and weighted by min(output
// rate, input rate) time units into a window of in_rate units; a frame that
// crosses the window end is split, and the closed window gives one sample,
// its mean rounded to nearest with ties away from zero and saturated to 16
// bits. One frame is worked at a time. A frame that closes no window passes
// only through the bit-serial multiplier, which adds one bit of the weight
// per cycle. A frame that closes a window takes the first weighted add, then
// a 16-step restoring divider (one quotient bit per cycle) that runs beside
// the serial multiply for the carried remainder, plus any wait while the
// previous sample still sits unread. A finished sample sits in the output
// register, and the next frame is taken while it waits. Writing either rate
// register restarts the window.
// ----------------------------------------------------------------------------
module stereo_box_average_downsampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [sbad_pkg::RateW-1:0]       cfg_data_i,
  // frame input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [sbad_pkg::SampleW-1:0] left_i,
  input  logic signed [sbad_pkg::SampleW-1:0] right_i,
  // sample output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sbad_pkg::SampleW-1:0] mono_sample_o
);

  localparam int unsigned SampleW = sbad_pkg::SampleW;
  localparam int unsigned MixW    = sbad_pkg::MixW;
  localparam int unsigned RateW   = sbad_pkg::RateW;
  localparam int unsigned SumW    = sbad_pkg::SumW;
  localparam int unsigned DivRemW = sbad_pkg::DivRemW;
  localparam int unsigned DivCntW = sbad_pkg::DivCntW;

  sbad_pkg::state_e state_q, state_d;

  logic [RateW-1:0]   in_rate_q, in_rate_d;
  logic [RateW-1:0]   dst_rate_q, dst_rate_d;
  logic [SumW-1:0]    window_sum_q, window_sum_d;
  logic [RateW-1:0]   window_fill_q, window_fill_d;
  logic [MixW-1:0]    mix_q, mix_d;
  logic [SumW-1:0]    mcand_q, mcand_d;
  logic [RateW-1:0]   mplier_q, mplier_d;
  logic [RateW-1:0]   carry_q, carry_d;
  logic               emit_q, emit_d;
  logic               neg_q, neg_d;
  logic [DivRemW-1:0] div_rem_q, div_rem_d;
  logic [SampleW-1:0] div_quo_q, div_quo_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] mono_q, mono_d;

  logic               in_fire;
  logic [MixW-1:0]    mix;
  logic [RateW-1:0]   eff_out;
  logic [RateW-1:0]   fill_eff;
  logic [RateW-1:0]   space;
  logic [SumW-1:0]    mag;
  logic [SumW:0]      numer;
  logic [DivRemW-1:0] div_trial;
  logic [DivRemW-1:0] divisor;
  logic               div_ge;
  logic [SampleW-1:0] sat_val;

  assign in_stall_o    = (state_q != sbad_pkg::ST_IDLE);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = mono_q;

  assign mix      = {left_i[SampleW-1], left_i} + {right_i[SampleW-1], right_i};
  assign eff_out  = (dst_rate_q > in_rate_q) ? in_rate_q : dst_rate_q;
  assign fill_eff = (window_fill_q >= in_rate_q) ? '0 : window_fill_q;
  assign space    = in_rate_q - fill_eff;

  // magnitude plus half the divisor, so truncating division rounds to nearest
  assign mag   = window_sum_q[SumW-1] ? (~window_sum_q + 1'b1) : window_sum_q;
  assign numer = {1'b0, mag} + {{(SumW+1-RateW){1'b0}}, in_rate_q};

  assign divisor   = {1'b0, in_rate_q, 1'b0};
  assign div_trial = {div_rem_q[DivRemW-2:0], div_quo_q[SampleW-1]};
  assign div_ge    = (div_trial >= divisor);

  always_comb begin
    if (neg_q) begin
      sat_val = (div_quo_q > sbad_pkg::MonoMin) ? sbad_pkg::MonoMin : (~div_quo_q + 1'b1);
    end else begin
      sat_val = (div_quo_q > sbad_pkg::MonoMax) ? sbad_pkg::MonoMax : div_quo_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_rate_d     = in_rate_q;
    dst_rate_d    = dst_rate_q;
    window_sum_d  = window_sum_q;
    window_fill_d = window_fill_q;
    mix_d         = mix_q;
    mcand_d       = mcand_q;
    mplier_d      = mplier_q;
    carry_d       = carry_q;
    emit_d        = emit_q;
    neg_d         = neg_q;
    div_rem_d     = div_rem_q;
    div_quo_d     = div_quo_q;
    div_cnt_d     = div_cnt_q;
    mono_d        = mono_q;
    out_valid_d   = out_valid_q && out_stall_i;

    unique case (state_q)
      sbad_pkg::ST_IDLE: begin
        if (in_fire && (eff_out != '0)) begin
          mix_d   = mix;
          mcand_d = {{(SumW-MixW){mix[MixW-1]}}, mix};
          if (window_fill_q >= in_rate_q) begin
            window_sum_d = '0;
          end
          if (eff_out < space) begin
            mplier_d      = eff_out;
            window_fill_d = fill_eff + eff_out;
            emit_d        = 1'b0;
          end else begin
            mplier_d      = space;
            carry_d       = eff_out - space;
            window_fill_d = eff_out - space;
            emit_d        = 1'b1;
          end
          state_d = sbad_pkg::ST_MUL;
        end
      end
      sbad_pkg::ST_MUL: begin
        if (mplier_q == '0) begin
          state_d = emit_q ? sbad_pkg::ST_PREP : sbad_pkg::ST_IDLE;
        end else begin
          if (mplier_q[0]) begin
            window_sum_d = window_sum_q + mcand_q;
          end
          mcand_d  = {mcand_q[SumW-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[RateW-1:1]};
        end
      end
      sbad_pkg::ST_PREP: begin
        neg_d        = window_sum_q[SumW-1];
        div_rem_d    = numer[SumW-1:SampleW];
        div_quo_d    = numer[SampleW-1:0];
        div_cnt_d    = DivCntW'(sbad_pkg::DivSteps);
        window_sum_d = '0;
        mplier_d     = carry_q;
        mcand_d      = {{(SumW-MixW){mix_q[MixW-1]}}, mix_q};
        state_d      = sbad_pkg::ST_DIV;
      end
      sbad_pkg::ST_DIV: begin
        // divider and carried-weight multiply share these cycles
        if (div_cnt_q != '0) begin
          div_rem_d = div_ge ? (div_trial - divisor) : div_trial;
          div_quo_d = {div_quo_q[SampleW-2:0], div_ge};
          div_cnt_d = div_cnt_q - 1'b1;
        end
        if (mplier_q != '0) begin
          if (mplier_q[0]) begin
            window_sum_d = window_sum_q + mcand_q;
          end
          mcand_d  = {mcand_q[SumW-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[RateW-1:1]};
        end
        if ((div_cnt_q == '0) && (mplier_q == '0)) begin
          state_d = sbad_pkg::ST_OUT;
        end
      end
      sbad_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          mono_d      = sat_val;
          out_valid_d = 1'b1;
          state_d     = sbad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbad_pkg::ST_IDLE;
      end
    endcase

    // a rate change restarts the window
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbad_pkg::CFG_IN_RATE:  in_rate_d  = cfg_data_i;
        sbad_pkg::CFG_DST_RATE: dst_rate_d = cfg_data_i;
        default:                in_rate_d  = in_rate_q;
      endcase
      window_sum_d  = '0;
      window_fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sbad_pkg::ST_IDLE;
      in_rate_q     <= sbad_pkg::InRateRst;
      dst_rate_q    <= sbad_pkg::OutRateRst;
      window_sum_q  <= '0;
      window_fill_q <= '0;
      emit_q        <= 1'b0;
      mplier_q      <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      in_rate_q     <= in_rate_d;
      dst_rate_q    <= dst_rate_d;
      window_sum_q  <= window_sum_d;
      window_fill_q <= window_fill_d;
      emit_q        <= emit_d;
      mplier_q      <= mplier_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q     <= mix_d;
    mcand_q   <= mcand_d;
    carry_q   <= carry_d;
    neg_q     <= neg_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    mono_q    <= mono_d;
  end

  // the window never holds more time than its length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (window_fill_q < in_rate_q) || (window_fill_q == '0))
    else $error("window fill reached window length");

  // partial remainder stays below the divisor through the division
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbad_pkg::ST_DIV) |-> (div_rem_q < divisor))
    else $error("divider remainder out of range");

  // the serial multiplier drains by one bit per cycle
  a_mul_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sbad_pkg::ST_MUL) && (mplier_q != '0)) |=> (mplier_q < $past(mplier_q)))
    else $error("multiplier did not advance");

  // a sample is only formed once both serial units have finished
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbad_pkg::ST_OUT) |-> ((div_cnt_q == '0) && (mplier_q == '0)))
    else $error("output formed before divide or multiply finished");

endmodule

/* dv/stereo_box_average_downsampler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_box_average_downsampler_tb
// Self-checking bench for the stereo box-average downsampler.
// ----------------------------------------------------------------------------
// An initial block steps through rate settings and queues stereo frames for a
// clocked driver. Each accepted frame goes through an exact integer window
// predictor, and a clocked monitor compares every output sample with the
// oldest predicted window mean. Both sides idle at random, the receiver holds
// off once for a long stretch, and the sender drains once in mid-phase.
// ----------------------------------------------------------------------------
module stereo_box_average_downsampler_tb;

  localparam int unsigned SampleW = sbad_pkg::SampleW;
  localparam int unsigned RateW = sbad_pkg::RateW;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = sbad_pkg::CFG_IN_RATE;
  logic [RateW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SampleW-1:0] left_i = '0;
  logic signed [SampleW-1:0] right_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SampleW-1:0] mono_sample_o;

  // predictor copy of the registers and the open window
  logic [RateW-1:0] rate_in = sbad_pkg::InRateRst;
  logic [RateW-1:0] rate_out = sbad_pkg::OutRateRst;
  longint win_sum = 0;
  longint win_fill = 0;

  frame_t frame_q[$];
  logic signed [SampleW-1:0] window_means_q[$];
  frame_t next_frame;
  logic signed [SampleW-1:0] want;

  bit calm = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  stereo_box_average_downsampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .left_i        (left_i),
    .right_i       (right_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mono_sample_o (mono_sample_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic signed [SampleW-1:0] window_mean(longint acc, longint width);
    longint mag;
    longint q;
    mag = (acc < 0) ? -acc : acc;
    q = (mag + width) / (2 * width);
    if (acc < 0) begin
      return (q > 32768) ? sbad_pkg::MonoMin : SampleW'(-q);
    end
    return (q > 32767) ? sbad_pkg::MonoMax : SampleW'(q);
  endfunction

  task automatic absorb_frame(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r);
    longint mix;
    longint ir;
    longint wt;
    longint span;
    longint carry;
    mix = longint'(l) + longint'(r);
    ir = longint'(rate_in);
    wt = (rate_out > rate_in) ? ir : longint'(rate_out);
    // a frame with no weight carries no time
    if (wt == 0) return;
    if (win_fill >= ir) begin
      win_sum = 0;
      win_fill = 0;
    end
    span = ir - win_fill;
    if (wt < span) begin
      win_sum += mix * wt;
      win_fill += wt;
    end else begin
      win_sum += mix * span;
      window_means_q = {window_means_q, window_mean(win_sum, ir)};
      carry = wt - span;
      win_sum = mix * carry;
      win_fill = carry;
    end
  endtask

  // driver, plus predictor updates on every register write and frame transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == sbad_pkg::CFG_IN_RATE) begin
          rate_in = cfg_data_i;
        end else begin
          rate_out = cfg_data_i;
        end
        win_sum = 0;
        win_fill = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        absorb_frame(left_i, right_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (frame_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          next_frame = frame_q.pop_front();
          in_valid_i <= 1'b1;
          left_i <= next_frame.left;
          right_i <= next_frame.right;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (window_means_q.size() == 0) begin
          mismatches++;
          $display("%0t: mono_sample expected none actual %0d", $time, mono_sample_o);
        end else begin
          want = window_means_q.pop_front();
          if (mono_sample_o !== want) begin
            mismatches++;
            $display("%0t: mono_sample expected %0d actual %0d", $time, want, mono_sample_o);
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= LongHold;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [SampleW-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 16'sh7fff;
    if (pick == 1) return 16'sh8000;
    if (pick == 2) return SampleW'($urandom_range(3)) - 16'sd1;
    if (pick == 3) return SampleW'($urandom_range(200)) - 16'sd100;
    return SampleW'($urandom);
  endfunction

  task automatic push_frame(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r);
    frame_t f;
    f.left = l;
    f.right = r;
    frame_q = {frame_q, f};
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      push_frame(rand_sample(), rand_sample());
    end
  endtask

  // every queued frame taken and every predicted sample seen
  task automatic wait_drained();
    do @(negedge clk_i);
    while (frame_q.size() != 0 || in_valid_i || window_means_q.size() != 0);
  endtask

  // the last frames may close no window while the block is still busy on them
  task automatic set_rates(logic [RateW-1:0] ir, logic [RateW-1:0] orr);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= sbad_pkg::CFG_IN_RATE;
    cfg_data_i <= ir;
    @(posedge clk_i);
    cfg_index_i <= sbad_pkg::CFG_DST_RATE;
    cfg_data_i <= orr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(logic [RateW-1:0] ir, logic [RateW-1:0] orr, int n);
    set_rates(ir, orr);
    push_random(n);
  endtask

  initial begin
    int unsigned ir;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset rates, field extremes
    push_frame(16'sh7fff, 16'sh7fff);
    push_frame(16'sh8000, 16'sh8000);
    push_frame(16'sh7fff, 16'sh8000);
    push_frame(16'sh8000, 16'sh7fff);
    push_frame(16'sh0000, 16'sh0000);
    push_frame(-16'sd1, -16'sd1);
    push_frame(16'sd1, 16'sd0);
    push_frame(16'sh5555, -16'sh5556);

    // integer ratio, frames end exactly on window boundaries
    set_rates(18'd48000, 18'd16000);
    push_frame(16'sd1000, -16'sd3000);
    push_frame(16'sh7fff, 16'sh7fff);
    push_frame(-16'sd5, 16'sd7);
    push_frame(16'sh8000, 16'sd0);
    push_frame(16'sd123, 16'sd456);
    push_frame(16'sh8000, 16'sh8000);

    // one unit windows, ties round away from zero
    set_rates(18'd1, 18'd1);
    push_frame(16'sd1, 16'sd0);
    push_frame(-16'sd1, 16'sd0);
    push_frame(16'sd3, 16'sd0);
    push_frame(-16'sd3, 16'sd0);

    // output rate above input rate gets clamped
    set_rates(18'd8000, 18'd192000);
    push_frame(16'sh7fff, 16'sd1);
    push_frame(-16'sd77, 16'sd76);

    // zero rates, frames are ignored
    set_rates(18'd0, 18'd16000);
    push_frame(16'sd100, 16'sd200);
    push_frame(16'sh8000, 16'sh7fff);
    set_rates(18'd44100, 18'd0);
    push_frame(16'sd300, -16'sd400);

    // long receiver hold while frames keep coming
    set_rates(18'd44100, 18'd16000);
    push_random(60);
    hold_reqs <= hold_reqs + 1;

    set_rates(18'h3ffff, 18'h3ffff);
    calm <= 1'b1;
    push_random(40);
    wait_drained();
    calm <= 1'b0;

    // sender waits for every sample in the middle of a window sequence
    random_phase(18'd192000, 18'd44100, 25);
    wait_drained();
    push_random(25);

    random_phase(18'h3ffff, 18'd131071, 40);
    random_phase(18'd11025, 18'd8000, 40);
    random_phase(18'd7, 18'd3, 40);
    random_phase(18'd96000, 18'd48000, 40);
    random_phase(18'd1, 18'h3ffff, 30);
    random_phase(18'd0, 18'd0, 10);
    random_phase(18'd8000, 18'd8000, 40);
    random_phase(18'd150001, 18'd65537, 40);
    for (int k = 0; k < 2; k++) begin
      ir = $urandom_range(262143, 8000);
      random_phase(RateW'(ir), RateW'($urandom_range(ir, ir / 6)), 30);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && window_means_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
